[src/cmap_glyph_index_lookup_unit_assert.svh]
// assertion macros for the cmap glyph index lookup unit
`ifndef CMAP_GLYPH_INDEX_LOOKUP_UNIT_ASSERT_SVH
`define CMAP_GLYPH_INDEX_LOOKUP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CMAP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmap assertion failed");
`define CMAP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmap assertion failed");
`else
`define CMAP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CMAP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/cmap_pkg.sv]
// types and constants of the cmap glyph index lookup unit
`timescale 1ns / 1ps
`default_nettype none
package cmap_pkg;
   localparam logic [15:0] FMT_BYTE  = 16'd0;
   localparam logic [15:0] FMT_SEG   = 16'd4;
   localparam logic [15:0] FMT_TRIM  = 16'd6;
   localparam logic [15:0] FMT_SEGM  = 16'd12;
   localparam logic [15:0] FMT_MANY  = 16'd13;
   localparam logic [15:0] MAX16     = 16'hffff;
   localparam logic [31:0] ENDS_OFS  = 32'd14;
   localparam logic [31:0] GRP_OFS   = 32'd16;
   localparam logic [31:0] GRP_BYTES = 32'd12;
   localparam logic [2:0]  RD8       = 3'd1;
   localparam logic [2:0]  RD16      = 3'd2;
   localparam logic [2:0]  RD32      = 3'd4;

   typedef enum logic [21:0] {
      S_IDLE     = 22'h000001,
      S_FMT      = 22'h000002,
      S_F0_LEN   = 22'h000004,
      S_F0_GLY   = 22'h000008,
      S_F6_FIRST = 22'h000010,
      S_F6_CNT   = 22'h000020,
      S_F6_GLY   = 22'h000040,
      S_F4_SEGX2 = 22'h000080,
      S_F4_RANGE = 22'h000100,
      S_F4_STEPS = 22'h000200,
      S_F4_SHIFT = 22'h000400,
      S_F4_PRB0  = 22'h000800,
      S_F4_STEP  = 22'h001000,
      S_F4_PRB   = 22'h002000,
      S_F4_SEG   = 22'h004000,
      S_F4_SEG2  = 22'h008000,
      S_F4_START = 22'h010000,
      S_F4_RO    = 22'h020000,
      S_F4_DELTA = 22'h040000,
      S_F4_ROGLY = 22'h080000,
      S_G_HI     = 22'h100000,
      S_G_MID    = 22'h200000
   } state_type;

   // group search states sit in a second enum to keep the first narrow
   typedef enum logic [5:0] {
      G_NONE = 6'h01,
      G_ADDR = 6'h02,
      G_S    = 6'h04,
      G_E    = 6'h08,
      G_GLY  = 6'h10,
      G_FIN  = 6'h20
   } gstate_type;
endpackage
`default_nettype wire

[src/cmap_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cmap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] addr,
   input  wire [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
endmodule
`default_nettype wire

[src/cmap_glyph_index_lookup_unit.sv]
// top level of the cmap glyph index lookup unit
//
//   channel   ports                                              direction
//   req       req_valid/ready, kind, load_address, load_byte,   in
//             codepoint
//   rsp       rsp_valid/ready, glyph_index, format_supported    out
//   csr       csr_valid/ready, subtable_offset                  in
//
// a load beat writes one byte and gives no result
// a lookup reads the font memory one byte per cycle, one field at a time:
//   format 4 runs a search of up to 16 steps, formats 12/13 a group search
//   of up to 32 steps
// the single memory port sets the read pace; one lookup is worked at a time
// reset is synchronous; the font memory has no reset and no clearing pass
// a finished result waits in the rsp register while loads are still taken
`timescale 1ns / 1ps
`default_nettype none
`include "cmap_glyph_index_lookup_unit_assert.svh"
module cmap_glyph_index_lookup_unit
   import cmap_pkg::*;
#(
   parameter int FONT_ADDR_BITS = 20
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_kind,
   input  wire  [19:0] req_load_address,
   input  wire  [7:0]  req_load_byte,
   input  wire  [20:0] req_codepoint,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_glyph_index,
   output logic        rsp_format_supported,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [19:0] csr_subtable_offset
);
   localparam int AW    = FONT_ADDR_BITS;
   localparam int DEPTH = 1 << FONT_ADDR_BITS;

   // main sequencer
   state_type  state_ff, state_in;
   gstate_type gst_ff, gst_in;
   logic [19:0] offset_ff;
   logic [20:0] cp_ff, cp_in;
   logic        per_char_ff, per_char_in;
   logic        sup_ff, sup_in;
   logic [31:0] glyph_ff, glyph_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] segx2_ff, segx2_in;
   logic [15:0] range_ff, range_in;
   logic [4:0]  steps_ff, steps_in;
   logic [14:0] shift_ff, shift_in;
   logic [31:0] delta_ff, delta_in;
   logic [15:0] seg_ff, seg_in;
   logic [31:0] roa_ff, roa_in;
   logic [31:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, rec_ff, rec_in;
   logic [31:0] s_ff, s_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_glyph_ff, rsp_glyph_in;
   logic        rsp_sup_ff, rsp_sup_in;

   // byte reader
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [2:0]    rd_left_ff, rd_left_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [31:0]   acc_ff, acc_in;
   logic          rd_go, rd_done;
   logic [31:0]   rd_go_addr;
   logic [2:0]    rd_go_len;
   logic [31:0]   rd_val;

   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_rdata;
   logic          ram_we;

   logic [31:0] base32, cp32, la32, acc16_32, first32, dp2, seg2_32, segx2_32;
   logic [15:0] acc16;
   logic        req_take, fin_go;

   assign csr_ready            = 1'b1;
   assign req_ready            = (state_ff == S_IDLE) && (gst_ff == G_NONE);
   assign req_take             = req_valid && req_ready;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_glyph_index      = rsp_glyph_ff;
   assign rsp_format_supported = rsp_sup_ff;

   assign base32   = {12'd0, offset_ff};
   assign cp32     = {11'd0, cp_ff};
   assign la32     = {12'd0, req_load_address};
   assign rd_val   = {acc_ff[23:0], ram_rdata};
   assign acc16    = rd_val[15:0];
   assign acc16_32 = {16'd0, acc16};
   assign first32  = {16'd0, first_ff};
   assign dp2      = delta_ff + 32'd2;
   assign seg2_32  = {15'd0, seg_ff, 1'b0};
   assign segx2_32 = {16'd0, segx2_ff};
   assign rd_done  = rd_pend_ff && (rd_left_ff == 3'd0);

   assign ram_we   = req_take && !req_kind;
   assign ram_addr = (rd_left_ff != 3'd0) ? rd_addr_ff : la32[AW-1:0];

   cmap_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_font_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_load_byte),
      .rdata (ram_rdata)
   );

   // byte reader: one byte issued per cycle, big-endian shift into acc
   always_comb begin
      rd_addr_in = rd_addr_ff;
      rd_left_in = rd_left_ff;
      rd_pend_in = 1'b0;
      acc_in     = rd_pend_ff ? rd_val : acc_ff;
      if (rd_left_ff != 3'd0) begin
         rd_addr_in = rd_addr_ff + AW'(1);
         rd_left_in = rd_left_ff - 3'd1;
         rd_pend_in = 1'b1;
      end
      if (rd_go) begin
         rd_addr_in = rd_go_addr[AW-1:0];
         rd_left_in = rd_go_len;
      end
   end

   // main sequencer
   always_comb begin
      state_in    = state_ff;
      gst_in      = gst_ff;
      cp_in       = cp_ff;
      per_char_in = per_char_ff;
      sup_in      = sup_ff;
      glyph_in    = glyph_ff;
      first_in    = first_ff;
      segx2_in    = segx2_ff;
      range_in    = range_ff;
      steps_in    = steps_ff;
      shift_in    = shift_ff;
      delta_in    = delta_ff;
      seg_in      = seg_ff;
      roa_in      = roa_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      rec_in      = rec_ff;
      s_in        = s_ff;
      rd_go       = 1'b0;
      rd_go_addr  = 32'd0;
      rd_go_len   = RD16;
      fin_go      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take && req_kind) begin
               cp_in      = req_codepoint;
               rd_go      = 1'b1;
               rd_go_addr = {12'd0, offset_ff};
               state_in   = S_FMT;
            end
         end
         S_FMT: begin
            if (rd_done) begin
               glyph_in = 32'd0;
               sup_in   = 1'b1;
               rd_go    = 1'b1;
               case (acc16)
                  FMT_BYTE: begin
                     rd_go_addr = base32 + 32'd2;
                     state_in   = S_F0_LEN;
                  end
                  FMT_TRIM: begin
                     rd_go_addr = base32 + 32'd6;
                     state_in   = S_F6_FIRST;
                  end
                  FMT_SEG: begin
                     rd_go_addr = base32 + 32'd6;
                     state_in   = S_F4_SEGX2;
                  end
                  FMT_SEGM, FMT_MANY: begin
                     per_char_in = (acc16 == FMT_SEGM);
                     rd_go_addr  = base32 + GRP_BYTES;
                     rd_go_len   = RD32;
                     state_in    = S_G_HI;
                  end
                  default: begin
                     rd_go  = 1'b0;
                     sup_in = 1'b0;
                     fin_go = 1'b1;
                  end
               endcase
            end
         end
         S_F0_LEN: begin
            if (rd_done) begin
               if (acc16 > 16'd6 && cp32 < acc16_32 - 32'd6) begin
                  rd_go      = 1'b1;
                  rd_go_addr = base32 + 32'd6 + cp32;
                  rd_go_len  = RD8;
                  state_in   = S_F0_GLY;
               end else begin
                  fin_go = 1'b1;
               end
            end
         end
         S_F0_GLY: begin
            if (rd_done) begin
               glyph_in = {24'd0, rd_val[7:0]};
               fin_go   = 1'b1;
            end
         end
         S_F6_FIRST: begin
            if (rd_done) begin
               first_in   = acc16;
               rd_go      = 1'b1;
               rd_go_addr = base32 + 32'd8;
               state_in   = S_F6_CNT;
            end
         end
         S_F6_CNT: begin
            if (rd_done) begin
               if (cp32 >= first32 && cp32 < first32 + acc16_32) begin
                  rd_go      = 1'b1;
                  rd_go_addr = base32 + 32'd10 + ((cp32 - first32) << 1);
                  state_in   = S_F6_GLY;
               end else begin
                  fin_go = 1'b1;
               end
            end
         end
         S_F6_GLY: begin
            if (rd_done) begin
               glyph_in = acc16_32;
               fin_go   = 1'b1;
            end
         end
         S_F4_SEGX2: begin
            if (rd_done) begin
               segx2_in   = {acc16[15:1], 1'b0};
               rd_go      = 1'b1;
               rd_go_addr = base32 + 32'd8;
               state_in   = S_F4_RANGE;
            end
         end
         S_F4_RANGE: begin
            if (rd_done) begin
               range_in   = {1'b0, acc16[15:1]};
               rd_go      = 1'b1;
               rd_go_addr = base32 + 32'd10;
               state_in   = S_F4_STEPS;
            end
         end
         S_F4_STEPS: begin
            if (rd_done) begin
               steps_in   = (acc16 > 16'd16) ? 5'd16 : acc16[4:0];
               rd_go      = 1'b1;
               rd_go_addr = base32 + 32'd12;
               state_in   = S_F4_SHIFT;
            end
         end
         S_F4_SHIFT: begin
            if (rd_done) begin
               shift_in = acc16[15:1];
               if (cp_ff[20:16] != 5'd0) begin
                  // wide codepoint has no format 4 mapping
                  fin_go = 1'b1;
               end else begin
                  rd_go      = 1'b1;
                  rd_go_addr = base32 + ENDS_OFS + {16'd0, acc16[15:1], 1'b0};
                  state_in   = S_F4_PRB0;
               end
            end
         end
         S_F4_PRB0: begin
            if (rd_done) begin
               delta_in = ((cp_ff[15:0] >= acc16) ? {16'd0, shift_ff, 1'b0} : 32'd0)
                          - 32'd2;
               state_in = (steps_ff != 5'd0) ? S_F4_STEP : S_F4_SEG;
            end
         end
         S_F4_STEP: begin
            range_in   = range_ff >> 1;
            steps_in   = steps_ff - 5'd1;
            rd_go      = 1'b1;
            rd_go_addr = base32 + ENDS_OFS + delta_ff + {16'd0, range_ff[15:1], 1'b0};
            state_in   = S_F4_PRB;
         end
         S_F4_PRB: begin
            if (rd_done) begin
               if ({11'd0, cp_ff} > {16'd0, acc16}) begin
                  delta_in = delta_ff + {15'd0, range_ff, 1'b0};
               end
               state_in = (steps_ff != 5'd0) ? S_F4_STEP : S_F4_SEG;
            end
         end
         S_F4_SEG: begin
            seg_in   = dp2[16:1];
            state_in = S_F4_SEG2;
         end
         S_F4_SEG2: begin
            rd_go      = 1'b1;
            rd_go_addr = base32 + ENDS_OFS + segx2_32 + 32'd2 + seg2_32;
            state_in   = S_F4_START;
         end
         S_F4_START: begin
            if (rd_done) begin
               first_in = acc16;
               if (cp_ff[15:0] < acc16) begin
                  fin_go = 1'b1;
               end else begin
                  roa_in     = base32 + ENDS_OFS + segx2_32 + {15'd0, segx2_ff, 1'b0}
                               + 32'd2 + seg2_32;
                  rd_go      = 1'b1;
                  rd_go_addr = roa_in;
                  state_in   = S_F4_RO;
               end
            end
         end
         S_F4_RO: begin
            if (rd_done) begin
               rd_go = 1'b1;
               if (acc16 == 16'd0) begin
                  rd_go_addr = base32 + ENDS_OFS + {15'd0, segx2_ff, 1'b0} + 32'd2
                               + seg2_32;
                  state_in   = S_F4_DELTA;
               end else begin
                  // offset lookup: the value read is the glyph, no delta
                  rd_go_addr = acc16_32 + ((cp32 - first32) << 1) + roa_ff;
                  state_in   = S_F4_ROGLY;
               end
            end
         end
         S_F4_DELTA: begin
            if (rd_done) begin
               glyph_in = {16'd0, cp_ff[15:0] + acc16};
               fin_go   = 1'b1;
            end
         end
         S_F4_ROGLY: begin
            if (rd_done) begin
               glyph_in = acc16_32;
               fin_go   = 1'b1;
            end
         end
         S_G_HI: begin
            if (rd_done) begin
               hi_in    = rd_val;
               lo_in    = 32'd0;
               state_in = S_G_MID;
            end
         end
         S_G_MID: begin
            if (gst_ff == G_NONE) begin
               if (lo_ff < hi_ff) begin
                  mid_in = lo_ff + ((hi_ff - lo_ff) >> 1);
                  gst_in = G_ADDR;
               end else begin
                  fin_go = 1'b1;
               end
            end else begin
               case (gst_ff)
                  G_ADDR: begin
                     rec_in     = base32 + GRP_OFS + 32'(mid_ff * GRP_BYTES);
                     rd_go      = 1'b1;
                     rd_go_addr = rec_in;
                     rd_go_len  = RD32;
                     gst_in     = G_S;
                  end
                  G_S: begin
                     if (rd_done) begin
                        s_in       = rd_val;
                        rd_go      = 1'b1;
                        rd_go_addr = rec_ff + 32'd4;
                        rd_go_len  = RD32;
                        gst_in     = G_E;
                     end
                  end
                  G_E: begin
                     if (rd_done) begin
                        if (cp32 < s_ff) begin
                           hi_in  = mid_ff;
                           gst_in = G_NONE;
                        end else if (cp32 > rd_val) begin
                           lo_in  = mid_ff + 32'd1;
                           gst_in = G_NONE;
                        end else begin
                           rd_go      = 1'b1;
                           rd_go_addr = rec_ff + 32'd8;
                           rd_go_len  = RD32;
                           gst_in     = G_GLY;
                        end
                     end
                  end
                  G_GLY: begin
                     if (rd_done) begin
                        glyph_in = per_char_ff ? rd_val + cp32 - s_ff : rd_val;
                        gst_in   = G_FIN;
                     end
                  end
                  G_FIN: begin
                     fin_go = 1'b1;
                  end
                  default: begin
                     gst_in = G_NONE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hand the result over once the rsp slot is free, else hold here
      if (fin_go) begin
         if (!rsp_valid_ff || rsp_ready) begin
            state_in = S_IDLE;
            gst_in   = G_NONE;
         end else begin
            // park in group finish until the slot drains
            state_in = S_G_MID;
            gst_in   = G_FIN;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_sup_in   = rsp_sup_ff;
      if (fin_go && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_glyph_in = glyph_in;
         rsp_sup_in   = sup_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gst_ff       <= G_NONE;
         offset_ff    <= 20'd0;
         rd_left_ff   <= 3'd0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gst_ff       <= gst_in;
         rd_left_ff   <= rd_left_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            offset_ff <= csr_subtable_offset;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cp_ff        <= cp_in;
      per_char_ff  <= per_char_in;
      sup_ff       <= sup_in;
      glyph_ff     <= glyph_in;
      first_ff     <= first_in;
      segx2_ff     <= segx2_in;
      range_ff     <= range_in;
      steps_ff     <= steps_in;
      shift_ff     <= shift_in;
      delta_ff     <= delta_in;
      seg_ff       <= seg_in;
      roa_ff       <= roa_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      rec_ff       <= rec_in;
      s_ff         <= s_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_sup_ff   <= rsp_sup_in;
      rd_addr_ff   <= rd_addr_in;
      acc_ff       <= acc_in;
   end

   // reader is quiet whenever a new beat can be taken
   `CMAP_ASSERT_IMP(a_idle_quiet, clock, reset, req_ready, (rd_left_ff == 3'd0) && !rd_pend_ff)
   // a read is only launched when the reader is free or finishing
   `CMAP_ASSERT_IMP(a_go_free, clock, reset, rd_go,
                    (rd_left_ff == 3'd0) && (!rd_pend_ff || rd_done))
   // unsupported format always reports glyph zero
   `CMAP_ASSERT_IMP(a_unsup_zero, clock, reset, rsp_valid_ff && !rsp_sup_ff, rsp_glyph_ff == 32'd0)
   // a lookup beat always starts with the format read
   `CMAP_ASSERT_NXT(a_start_fmt, clock, reset, req_take && req_kind,
                    (state_ff == S_FMT) && (rd_left_ff == RD16))
endmodule
`default_nettype wire

[tb/sv/cmap_tb_pkg.sv]
// beat kinds and result record shared by the cmap testbench files
`timescale 1ns / 1ps
package cmap_tb_pkg;
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic [31:0] glyph;
      logic        supported;
   } glyph_result_type;
endpackage

[tb/sv/cmap_lookup_checker.sv]
// font image mirror, glyph predictor and result comparator for the cmap unit
`timescale 1ns / 1ps
module cmap_lookup_checker
   import cmap_pkg::*;
   import cmap_tb_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire         req_kind,
   input  wire  [19:0] req_load_address,
   input  wire  [7:0]  req_load_byte,
   input  wire  [20:0] req_codepoint,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire  [31:0] rsp_glyph_index,
   input  wire         rsp_format_supported,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [19:0] csr_subtable_offset,
   output int          mismatches,
   output int          outstanding,
   output int          glyphs_checked,
   output int          bytes_loaded,
   output int          offsets_set
);
   bit [7:0]         font_image [0:1048575];
   bit               written [0:1048575];
   logic [19:0]      table_base;
   bit               stray;
   glyph_result_type glyph_q [$];

   initial begin
      mismatches = 0;
      outstanding = 0;
      glyphs_checked = 0;
      bytes_loaded = 0;
      offsets_set = 0;
      table_base = '0;
   end

   // stray flags any read of a byte never loaded
   function automatic logic [31:0] rd8(logic [31:0] a);
      if (!written[a[19:0]]) stray = 1'b1;
      return {24'd0, font_image[a[19:0]]};
   endfunction

   function automatic logic [31:0] rd16(logic [31:0] a);
      return (rd8(a) << 8) | rd8(a + 1);
   endfunction

   function automatic logic [31:0] rd32(logic [31:0] a);
      return (rd8(a) << 24) | (rd8(a + 1) << 16) | (rd8(a + 2) << 8) | rd8(a + 3);
   endfunction

   function automatic logic [31:0] segment_glyph(logic [31:0] base, logic [31:0] cp);
      logic [31:0] segx2, span, steps, shift, ends, pos, seg, first, ro, ro_at, i;
      segx2 = (rd16(base + 6) >> 1) * 2;
      span  = rd16(base + 8) >> 1;
      steps = rd16(base + 10);
      shift = rd16(base + 12) >> 1;
      if (cp > {16'd0, MAX16}) return 32'd0;
      ends = base + ENDS_OFS;
      pos  = ends;
      if (cp >= rd16(pos + shift * 2)) pos = pos + shift * 2;
      pos = pos - 2;
      if (steps > 16) steps = 16;
      for (i = 0; i < steps; i++) begin
         span = span >> 1;
         if (cp > rd16(pos + span * 2)) pos = pos + span * 2;
      end
      pos   = pos + 2;
      seg   = ((pos - ends) >> 1) & 32'hffff;
      first = rd16(ends + segx2 + 2 + 2 * seg);
      if (cp < first) return 32'd0;
      ro_at = ends + segx2 * 3 + 2 + 2 * seg;
      ro    = rd16(ro_at);
      // no delta after an offset lookup
      if (ro == 0) return (cp + rd16(ends + segx2 * 2 + 2 + 2 * seg)) & 32'hffff;
      return rd16(ro + (cp - first) * 2 + ro_at);
   endfunction

   function automatic logic [31:0] group_glyph(logic [31:0] base, logic [31:0] cp,
                                               bit per_char);
      logic [31:0] lo, hi, mid, rec, s, e;
      lo = 0;
      hi = rd32(base + 12);
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         rec = base + GRP_OFS + mid * GRP_BYTES;
         s = rd32(rec);
         e = rd32(rec + 4);
         if (cp < s) hi = mid;
         else if (cp > e) lo = mid + 1;
         else return per_char ? rd32(rec + 8) + (cp - s) : rd32(rec + 8);
      end
      return 32'd0;
   endfunction

   function automatic glyph_result_type lookup_glyph(logic [20:0] codepoint);
      glyph_result_type r;
      logic [31:0] base, cp, fmt, len, first, count;
      base = {12'd0, table_base};
      cp   = {11'd0, codepoint};
      fmt  = rd16(base);
      r.glyph = '0;
      r.supported = 1'b1;
      case (fmt[15:0])
         FMT_BYTE: begin
            len = rd16(base + 2);
            if (len > 6 && cp < len - 6) r.glyph = rd8(base + 6 + cp);
         end
         FMT_TRIM: begin
            first = rd16(base + 6);
            count = rd16(base + 8);
            if (cp >= first && cp < first + count)
               r.glyph = rd16(base + 10 + (cp - first) * 2);
         end
         FMT_SEG:  r.glyph = segment_glyph(base, cp);
         FMT_SEGM: r.glyph = group_glyph(base, cp, 1'b1);
         FMT_MANY: r.glyph = group_glyph(base, cp, 1'b0);
         default:  r.supported = 1'b0;
      endcase
      return r;
   endfunction

   // true when a lookup of cp at the current offset touches only loaded bytes
   function automatic bit lookup_is_clean(logic [20:0] cp);
      glyph_result_type unused;
      stray = 1'b0;
      unused = lookup_glyph(cp);
      return !stray;
   endfunction

   always @(posedge clock) begin
      glyph_result_type want;
      if (reset) begin
         table_base = '0;
         glyph_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            table_base = csr_subtable_offset;
            offsets_set++;
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               font_image[req_load_address] = req_load_byte;
               written[req_load_address] = 1'b1;
               bytes_loaded++;
            end else begin
               glyph_q.push_back(lookup_glyph(req_codepoint));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (glyph_q.size() == 0) begin
               $error("result beat with no lookup waiting: glyph_index %0h", rsp_glyph_index);
               mismatches++;
            end else begin
               want = glyph_q.pop_front();
               glyphs_checked++;
               if (rsp_glyph_index !== want.glyph) begin
                  $error("glyph_index expected %0h actual %0h", want.glyph, rsp_glyph_index);
                  mismatches++;
               end
               if (rsp_format_supported !== want.supported) begin
                  $error("format_supported expected %0b actual %0b",
                         want.supported, rsp_format_supported);
                  mismatches++;
               end
            end
         end
      end
      outstanding = glyph_q.size();
   end
endmodule

[tb/sv/tb_cmap_glyph_index_lookup_unit.sv]
// stimulus and verdict for the cmap glyph index lookup unit
`timescale 1ns / 1ps
module tb_cmap_glyph_index_lookup_unit
   import cmap_pkg::*;
   import cmap_tb_pkg::*;
();

   localparam int          ITEM_TARGET = 1750;
   localparam int          CYCLE_LIMIT = 1500000;
   localparam logic [15:0] FMT_HIBYTE  = 16'd2;   // high-byte mapping, not handled
   localparam logic [15:0] FMT_ODD     = 16'd7;
   localparam logic [20:0] CP_TOP      = 21'h10ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_LOAD;
   logic [19:0] req_load_address = '0;
   logic [7:0]  req_load_byte = '0;
   logic [20:0] req_codepoint = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_glyph_index;
   logic        rsp_format_supported;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [19:0] csr_subtable_offset = '0;

   int mismatches, outstanding, glyphs_checked, bytes_loaded, offsets_set;
   int idle_pct = 0;          // chance per cycle the sender holds off
   int stall_pct = 0;         // chance per cycle the receiver stalls
   int beats_sent = 0;
   int cycle_count = 0;
   logic [20:0] hot_cps [$];  // codepoints near table boundaries

   cmap_glyph_index_lookup_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_load_address(req_load_address), .req_load_byte(req_load_byte),
      .req_codepoint(req_codepoint),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_glyph_index(rsp_glyph_index),
      .rsp_format_supported(rsp_format_supported),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_subtable_offset(csr_subtable_offset)
   );

   cmap_lookup_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_load_address(req_load_address), .req_load_byte(req_load_byte),
      .req_codepoint(req_codepoint),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_glyph_index(rsp_glyph_index),
      .rsp_format_supported(rsp_format_supported),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_subtable_offset(csr_subtable_offset),
      .mismatches(mismatches), .outstanding(outstanding), .glyphs_checked(glyphs_checked),
      .bytes_loaded(bytes_loaded), .offsets_set(offsets_set)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver stalls at random per cycle
   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   // hard stop for a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** cmap_glyph_index_lookup_unit: FAILED **");
         $finish;
      end
   end

   // called at an edge; may drop valid for a random gap set by min_gap and idle_pct
   task automatic pause_sender(input int min_gap);
      int gap;
      gap = min_gap;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drive_beat(input logic k, input logic [19:0] a, input logic [7:0] b,
                             input logic [20:0] cp);
      req_valid <= 1'b1;
      req_kind <= k;
      req_load_address <= a;
      req_load_byte <= b;
      req_codepoint <= cp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic put8(input logic [31:0] a, input logic [7:0] b);
      pause_sender(0);
      drive_beat(KIND_LOAD, a[19:0], b, 21'($urandom));
   endtask

   task automatic put16(input logic [31:0] a, input logic [15:0] v);
      put8(a, v[15:8]);
      put8(a + 1, v[7:0]);
   endtask

   task automatic put32(input logic [31:0] a, input logic [31:0] v);
      put16(a, v[31:16]);
      put16(a + 2, v[15:0]);
   endtask

   // lookups get a gap so the checker has seen every earlier load when probing
   task automatic lookup_beat(input logic [20:0] cp);
      pause_sender(1);
      if (chk.lookup_is_clean(cp))
         drive_beat(KIND_LOOKUP, 20'($urandom), 8'($urandom), cp);
   endtask

   task automatic add_hot(input logic [31:0] cp);
      if (cp <= CP_TOP) hot_cps.push_back(cp[20:0]);
      if (cp + 1 <= CP_TOP) hot_cps.push_back(cp[20:0] + 1);
      if (cp > 0 && cp - 1 <= CP_TOP) hot_cps.push_back(cp[20:0] - 1);
   endtask

   // sender pause until every lookup has answered, then a short settle
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_offset(input logic [19:0] ofs);
      csr_valid <= 1'b1;
      csr_subtable_offset <= ofs;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic build_byte_table(input logic [31:0] base);
      int n;
      n = $urandom_range(40);
      put16(base, FMT_BYTE);
      // now and then a length of six or less, which maps nothing
      put16(base + 2, ($urandom_range(9) == 0) ? 16'($urandom_range(6)) : 16'(n + 6));
      put16(base + 4, 16'($urandom));
      for (int i = 0; i < n; i++) put8(base + 6 + i, 8'($urandom));
      add_hot(0);
      add_hot(n);
   endtask

   task automatic build_trimmed_table(input logic [31:0] base);
      logic [15:0] first, count;
      first = 16'($urandom);
      count = 16'($urandom_range(12));
      put16(base, FMT_TRIM);
      put16(base + 2, 16'(10 + 2 * count));
      put16(base + 4, 16'd0);
      put16(base + 6, first);
      put16(base + 8, count);
      for (int i = 0; i < count; i++) put16(base + 10 + 2 * i, 16'($urandom));
      add_hot(first);
      add_hot(first + count);
   endtask

   // well-formed segment table; some segments map through the glyph array
   task automatic build_segment_table(input logic [31:0] base);
      int n, segx2, srange, sel, used;
      logic [31:0] ends, starts, deltas, ros, garr, ro_at;
      logic [15:0] s, e, cur;
      n = $urandom_range(1, 6);
      segx2 = 2 * n;
      srange = 2;
      sel = 0;
      while (srange * 2 <= segx2) begin
         srange *= 2;
         sel++;
      end
      ends = base + ENDS_OFS;
      starts = ends + segx2 + 2;
      deltas = starts + segx2;
      ros = deltas + segx2;
      garr = ros + segx2;
      put16(base, FMT_SEG);
      put16(base + 2, 16'(16 + 8 * n));
      put16(base + 4, 16'd0);
      put16(base + 6, 16'(segx2));
      put16(base + 8, 16'(srange));
      put16(base + 10, 16'(sel));
      put16(base + 12, 16'(segx2 - srange));
      put16(ends + segx2, 16'd0);
      cur = 16'($urandom_range(16'hf000));
      used = 0;
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) begin
            s = MAX16;
            e = MAX16;
         end else begin
            s = cur + 16'($urandom_range(20));
            e = s + 16'($urandom_range(7));
            cur = e + 1;
         end
         put16(ends + 2 * i, e);
         put16(starts + 2 * i, s);
         put16(deltas + 2 * i, 16'($urandom));
         ro_at = ros + 2 * i;
         if (i < n - 1 && $urandom_range(1) == 1) begin
            put16(ro_at, 16'(garr + 2 * used - ro_at));
            for (int j = 0; j <= e - s; j++) begin
               put16(garr + 2 * used, 16'($urandom));
               used++;
            end
         end else begin
            put16(ro_at, 16'd0);
         end
         add_hot(s);
         add_hot(e);
      end
   endtask

   task automatic build_group_table(input logic [31:0] base, input logic [15:0] fmt);
      int n;
      logic [31:0] cur, s, e, rec;
      n = $urandom_range(6);
      put16(base, fmt);
      put16(base + 2, 16'd0);
      put32(base + 4, 32'(16 + 12 * n));
      put32(base + 8, 32'd0);
      put32(base + 12, 32'(n));
      cur = $urandom_range(32'hf0000);
      for (int i = 0; i < n; i++) begin
         s = cur + $urandom_range(50);
         e = s + $urandom_range(30);
         cur = e + 1;
         rec = base + GRP_OFS + i * GRP_BYTES;
         put32(rec, s);
         put32(rec + 4, e);
         put32(rec + 8, $urandom);   // full range so start glyph + offset can wrap
         add_hot(s);
         add_hot(e);
      end
   endtask

   task automatic build_unsupported(input logic [31:0] base);
      logic [15:0] fmt;
      case ($urandom_range(2))
         0: fmt = FMT_HIBYTE;
         1: fmt = FMT_ODD;
         default: begin
            fmt = 16'($urandom);
            if (fmt == FMT_BYTE || fmt == FMT_SEG || fmt == FMT_TRIM ||
                fmt == FMT_SEGM || fmt == FMT_MANY) fmt = FMT_ODD;
         end
      endcase
      put16(base, fmt);
   endtask

   task automatic run_scene(input int scene, input logic [19:0] base);
      int tries;
      logic [20:0] cp;
      int r;
      // phases: free flow, sender gaps, receiver stalls, both
      case (scene % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 48; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 48; end
         default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      drain_all();
      set_offset(base);
      hot_cps.delete();
      case ($urandom_range(9))
         0, 1:    build_segment_table(base);
         2, 3:    build_group_table(base, FMT_SEGM);
         4:       build_group_table(base, FMT_MANY);
         5, 6:    build_trimmed_table(base);
         7, 8:    build_byte_table(base);
         default: build_unsupported(base);
      endcase
      for (int k = 0; k < 45; k++) begin
         r = $urandom_range(99);
         if (r < 6) begin
            put8($urandom, 8'($urandom));   // stray byte anywhere, may corrupt the table
         end else if (r < 8) begin
            drain_all();
         end else begin
            tries = 0;
            do begin
               r = $urandom_range(99);
               if (r < 65 && hot_cps.size() > 0) cp = hot_cps[$urandom_range(hot_cps.size() - 1)];
               else if (r < 85) cp = 21'($urandom_range(300));
               else cp = 21'($urandom_range(CP_TOP));
               tries++;
            end while (!chk.lookup_is_clean(cp) && tries < 8);
            lookup_beat(cp);
         end
      end
   endtask

   initial begin
      int scene;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte table at the top offset, wrapping through address zero
      set_offset(20'hfffff);
      put16(32'hfffff, FMT_BYTE);
      put16(32'h1, 16'd9);
      put16(32'h3, 16'hffff);
      put8(32'h5, 8'h00);
      put8(32'h6, 8'hff);
      put8(32'h7, 8'h5a);
      lookup_beat(21'd0);
      lookup_beat(21'd1);
      lookup_beat(21'd2);
      lookup_beat(21'd3);
      lookup_beat(CP_TOP);
      // same bytes at offset zero read as a long byte table
      drain_all();
      set_offset(20'h0);
      lookup_beat(21'd0);
      lookup_beat(CP_TOP);

      scene = 0;
      while (beats_sent < ITEM_TARGET) begin
         if (scene == 0) run_scene(scene, 20'h0);
         else if (scene == 1) run_scene(scene, 20'hffff0);
         else run_scene(scene, 20'($urandom));
         scene++;
      end

      drain_all();
      repeat (100) @(posedge clock);
      $display("covered %0d lookups checked, %0d font bytes loaded, %0d subtable offsets",
               glyphs_checked, bytes_loaded, offsets_set);
      $display("table scenes across formats 0, 4, 6, 12, 13 and unsupported: %0d", scene);
      if (mismatches == 0 && outstanding == 0) begin
         $display("** cmap_glyph_index_lookup_unit: PASSED **");
      end else begin
         $display("** cmap_glyph_index_lookup_unit: FAILED **");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+src
src/cmap_pkg.sv
src/cmap_ram.sv
src/cmap_glyph_index_lookup_unit.sv
tb/sv/cmap_tb_pkg.sv
tb/sv/cmap_lookup_checker.sv
tb/sv/tb_cmap_glyph_index_lookup_unit.sv
